>>> src/rxs_pkg.sv
`timescale 1ns / 1ps
package rxs_pkg;

  localparam int MAX_TEMPS = 64;
  localparam int SLOT_W    = 6;
  localparam int NT_W      = 7;
  localparam int TEMP_W    = 24;
  localparam int EN_W      = 32;
  localparam int CNT_W     = 32;
  localparam int FRAC_BITS = 16;
  // quotient of logw keeps four integer bits, since |logw| < 16 past the cutoff test
  localparam int INT_BITS  = 4;
  localparam int QUO_W     = INT_BITS + FRAC_BITS;
  localparam int POLY_DEG  = 13;
  localparam int APB_AW    = 4;

  localparam logic [32:0]       ONE_Q32 = 33'h1_0000_0000;
  localparam logic [TEMP_W-1:0] T_MAX   = 24'hFF_FFFF;

  localparam logic [NT_W-1:0]   NUM_TEMPS_RST  = 7'd2;
  localparam logic [TEMP_W-1:0] INI_TEMP_RST   = 24'd65536;
  localparam logic [TEMP_W-1:0] DELTA_TEMP_RST = 24'd6554;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXCH  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NUM_TEMPS  = 2'd0,
    REG_INI_TEMP   = 2'd1,
    REG_DELTA_TEMP = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

endpackage

>>> src/rxs_if.sv
`timescale 1ns / 1ps
interface rxs_req_if import rxs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [SLOT_W-1:0] slot;
  logic [EN_W-1:0]   energy;
  logic [31:0]       random;

  modport source (output valid, command, slot, energy, random, input ready);
  modport sink   (input valid, command, slot, energy, random, output ready);
endinterface

interface rxs_rsp_if import rxs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [SLOT_W-1:0] pair_index;
  logic              sweep_done;
  logic [SLOT_W-1:0] read_replica;
  logic [EN_W-1:0]   read_energy;
  logic [CNT_W-1:0]  read_attempts;
  logic [CNT_W-1:0]  read_accepts;

  modport source (output valid, accepted, pair_index, sweep_done, read_replica, read_energy,
                  read_attempts, read_accepts, input ready);
  modport sink   (input valid, accepted, pair_index, sweep_done, read_replica, read_energy,
                  read_attempts, read_accepts, output ready);
endinterface

>>> src/replica_exchange_swap.sv
`timescale 1ns / 1ps
// A full exchange runs 20 divider steps, 2 x 13 polynomial steps and one exp(-1) factor
// per whole unit of logw; one word in flight, ready only when idle. Each polynomial step
// works through the shared 32x32 multiplier and the radix-16 divider.
// Reset (rst, synchronous, active high): registers to defaults, sweep pointer to zero,
// replica map to identity and counters to zero at once through per-slot valid bits.
module replica_exchange_swap import rxs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rxs_req_if.sink           req,
  rxs_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_LOAD = 17'h00002,
    S_TEMP = 17'h00004,
    S_DIFF = 17'h00008,
    S_MAG  = 17'h00010,
    S_DEN  = 17'h00020,
    S_CHK  = 17'h00040,
    S_DIV  = 17'h00080,
    S_PMUL = 17'h00100,
    S_PLD  = 17'h00200,
    S_PDIV = 17'h00400,
    S_PUPD = 17'h00800,
    S_EMUL = 17'h01000,
    S_EUPD = 17'h02000,
    S_DEC  = 17'h04000,
    S_WR0  = 17'h08000,
    S_WR1  = 17'h10000
  } state_t;

  // S_DONE lives in its own flag so the sequencer enum stays the work states
  state_t state;
  logic   done;

  // configuration
  logic [NT_W-1:0]   num_temps;
  logic [TEMP_W-1:0] ini_temp;
  logic [TEMP_W-1:0] delta_temp;

  // captured word
  logic [1:0]        cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [31:0]       rnd_r;
  logic              exch_ok;

  logic [SLOT_W-1:0] pidx;
  logic [SLOT_W-1:0] nxt_pair;
  logic              last_r;
  logic              acc_f;

  // slot stores
  logic [EN_W-1:0]   en_mem  [MAX_TEMPS];
  logic [SLOT_W-1:0] rep_mem [MAX_TEMPS];
  logic [CNT_W-1:0]  att_mem [MAX_TEMPS];
  logic [CNT_W-1:0]  acc_mem [MAX_TEMPS];
  logic [MAX_TEMPS-1:0] rep_vld;
  logic [MAX_TEMPS-1:0] cnt_vld;

  logic [SLOT_W-1:0] ra0, ra1;
  logic [EN_W-1:0]   en_rd0, en_rd1;
  logic [SLOT_W-1:0] rep_rd0, rep_rd1;
  logic              rep_v0, rep_v1;
  logic [CNT_W-1:0]  att_rd, acc_rd;
  logic              cnt_v;
  logic [SLOT_W-1:0] rep0_val, rep1_val;
  logic [CNT_W-1:0]  att_val, acc_val;

  // arithmetic datapath
  logic signed [31:0] base;
  logic [TEMP_W-1:0]  ti, tj;
  logic [TEMP_W-1:0]  adt;
  logic [31:0]        ade;
  logic [55:0]        mag;
  logic [52:0]        rr;
  logic [50:0]        dd;
  logic [QUO_W-1:0]   qq;
  logic [4:0]         dcnt;
  logic [32:0]        f, pp, e1q;
  logic [3:0]         kk;
  logic               phase;
  logic [3:0]         ecnt;
  logic [35:0]        dv_n, dv_q;
  logic [3:0]         dv_r;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mq;

  logic [NT_W-1:0]    n_eff;
  logic               n_ok;
  logic [SLOT_W-1:0]  p_sel;
  logic signed [31:0] base_next;
  logic signed [24:0] dt;
  logic signed [32:0] de;
  logic [47:0]        den;
  logic               div_ge;
  logic [52:0]        rr_sub;
  logic [32:0]        mres;
  logic [8:0]         dig;
  logic [32:0]        poly_next;
  logic               last_next;
  logic               accept_in;
  logic               out_free;

  function automatic logic [TEMP_W-1:0] clamp_temp(input logic signed [32:0] t);
    logic [TEMP_W-1:0] r;
    if (t < 33'sd1) begin
      r = TEMP_W'(1);
    end else if (t > $signed({9'd0, T_MAX})) begin
      r = T_MAX;
    end else begin
      r = t[TEMP_W-1:0];
    end
    return r;
  endfunction

  // one radix-16 digit of a division by a small divisor: {quotient digit, remainder}
  function automatic logic [8:0] div_digit(input logic [3:0] r, input logic [3:0] d,
                                           input logic [3:0] k);
    logic [4:0] t;
    logic [3:0] rem;
    logic [3:0] q;
    rem = r;
    q   = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {rem, d[i]};
      if (t >= {1'b0, k}) begin
        t    = t - {1'b0, k};
        q[i] = 1'b1;
      end
      rem = t[3:0];
    end
    return {1'b0, q, rem};
  endfunction

  // Q0.32 product with 1.0 passed through exactly
  function automatic logic [32:0] mul_q32(input logic [32:0] a, input logic [32:0] b,
                                          input logic [63:0] prod);
    logic [32:0] r;
    if (a >= ONE_Q32) begin
      r = b;
    end else if (b >= ONE_Q32) begin
      r = a;
    end else begin
      r = {1'b0, prod[63:32]};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_NUM_TEMPS:  prdata = {25'd0, num_temps};
      REG_INI_TEMP:   prdata = {8'd0, ini_temp};
      REG_DELTA_TEMP: prdata = {8'd0, delta_temp};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_temps  <= NUM_TEMPS_RST;
      ini_temp   <= INI_TEMP_RST;
      delta_temp <= DELTA_TEMP_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_NUM_TEMPS:  num_temps  <= pwdata[NT_W-1:0];
        REG_INI_TEMP:   ini_temp   <= pwdata[TEMP_W-1:0];
        REG_DELTA_TEMP: delta_temp <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sweep pointer
  // clip the slot count to the store depth; fewer than two slots leaves exchanges inert
  assign n_eff = (num_temps > NT_W'(MAX_TEMPS)) ? NT_W'(MAX_TEMPS) : num_temps;
  assign n_ok  = (n_eff >= NT_W'(2));
  // restart the sweep when the pointer ran past a shrunken slot count
  assign p_sel = ({1'b0, nxt_pair} >= (n_eff - NT_W'(1))) ? '0 : nxt_pair;
  assign last_next = (({1'b0, pidx} + NT_W'(1)) >= (n_eff - NT_W'(1)));

  // lower slot temperature before clamping: ini + delta * p, all in 32 bits
  assign base_next = $signed({8'd0, ini_temp})
                   + ($signed({{8{delta_temp[TEMP_W-1]}}, delta_temp})
                      * $signed({26'd0, p_sel}));

  assign accept_in = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !done;
  assign out_free  = !rsp.valid || rsp.ready;

  // ---------------------------------------------------------------- stores
  assign ra0 = (cmd_r == CMD_READ) ? slot_r : pidx;
  assign ra1 = pidx + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      en_rd0  <= en_mem[ra0];
      en_rd1  <= en_mem[ra1];
      rep_rd0 <= rep_mem[ra0];
      rep_rd1 <= rep_mem[ra1];
      att_rd  <= att_mem[ra0];
      acc_rd  <= acc_mem[ra0];
      rep_v0  <= rep_vld[ra0];
      rep_v1  <= rep_vld[ra1];
      cnt_v   <= cnt_vld[ra0];
    end
  end

  // never-written entries read as their reset values
  assign rep0_val = rep_v0 ? rep_rd0 : ra0;
  assign rep1_val = rep_v1 ? rep_rd1 : ra1;
  assign att_val  = cnt_v ? att_rd : '0;
  assign acc_val  = cnt_v ? acc_rd : '0;

  always_ff @(posedge clk) begin
    if (accept_in && (cmd_t'(req.command) == CMD_WRITE)) begin
      en_mem[req.slot] <= req.energy;
    end else if (state == S_WR0 && acc_f) begin
      en_mem[pidx] <= en_rd1;
    end else if (state == S_WR1) begin
      en_mem[ra1] <= en_rd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WR0 && acc_f) begin
      rep_mem[pidx] <= rep1_val;
    end else if (state == S_WR1) begin
      rep_mem[ra1] <= rep0_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WR0) begin
      att_mem[pidx] <= att_val + CNT_W'(1);
      acc_mem[pidx] <= acc_val + CNT_W'(acc_f);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_vld <= '0;
      cnt_vld <= '0;
    end else begin
      if (state == S_WR0) begin
        cnt_vld[pidx] <= 1'b1;
        if (acc_f) begin
          rep_vld[pidx] <= 1'b1;
        end
      end
      if (state == S_WR1) begin
        rep_vld[ra1] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- shared units
  always_comb begin
    case (state)
      S_MAG: begin
        mul_a = {8'd0, adt};
        mul_b = ade;
      end
      S_DEN: begin
        mul_a = {8'd0, ti};
        mul_b = {8'd0, tj};
      end
      S_PMUL: begin
        mul_a = f[31:0];
        mul_b = pp[31:0];
      end
      S_EMUL: begin
        mul_a = pp[31:0];
        mul_b = e1q[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mq <= mul_a * mul_b;
  end

  assign dt     = $signed({1'b0, tj}) - $signed({1'b0, ti});
  assign de     = $signed({en_rd0[EN_W-1], en_rd0}) - $signed({en_rd1[EN_W-1], en_rd1});
  assign den    = mq[47:0];
  assign div_ge = ({2'b0, rr} >= {4'b0, dd});
  assign rr_sub = div_ge ? (rr - {2'b0, dd}) : rr;
  assign mres   = (state == S_EUPD) ? mul_q32(pp, e1q, mq) : mul_q32(f, pp, mq);
  assign dig    = div_digit(dv_r, dv_n[35:32], kk);
  assign poly_next = ONE_Q32 - dv_q[32:0];

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      nxt_pair <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (done) begin
            if (out_free) begin
              done <= 1'b0;
            end
          end else if (accept_in) begin
            cmd_r   <= req.command;
            slot_r  <= req.slot;
            rnd_r   <= req.random;
            exch_ok <= n_ok;
            pidx    <= p_sel;
            base    <= base_next;
            acc_f   <= 1'b0;
            case (cmd_t'(req.command))
              CMD_READ: state <= S_LOAD;
              CMD_EXCH: begin
                if (n_ok) begin
                  state <= S_LOAD;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_LOAD: begin
          if (cmd_r == CMD_READ) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_TEMP;
          end
        end
        S_TEMP: begin
          ti    <= clamp_temp({base[31], base});
          tj    <= clamp_temp({base[31], base} + 33'($signed(delta_temp)));
          state <= S_DIFF;
        end
        S_DIFF: begin
          adt <= dt[24] ? TEMP_W'(-dt) : dt[TEMP_W-1:0];
          ade <= de[32] ? 32'(-de) : de[31:0];
          // zero product or logw of matching sign: take the swap outright
          if (dt == '0 || de == '0 || (dt[24] == de[32])) begin
            acc_f <= 1'b1;
            state <= S_WR0;
          end else begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          state <= S_DEN;
        end
        S_DEN: begin
          mag   <= mq[55:0];
          state <= S_CHK;
        end
        S_CHK: begin
          // logw at -16 or below: exp taken as zero, reject
          if (mag >= {4'd0, den, 4'd0}) begin
            acc_f <= 1'b0;
            state <= S_WR0;
          end else begin
            rr    <= mag[52:0];
            dd    <= 51'({den, 3'd0});
            qq    <= '0;
            dcnt  <= 5'(QUO_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rr   <= rr_sub << 1;
          qq   <= {qq[QUO_W-2:0], div_ge};
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd0) begin
            // first pass builds exp(-1), second the fraction
            f     <= ONE_Q32;
            pp    <= ONE_Q32;
            kk    <= 4'(POLY_DEG);
            phase <= 1'b0;
            state <= S_PMUL;
          end
        end
        S_PMUL: begin
          state <= S_PLD;
        end
        S_PLD: begin
          dv_n  <= {3'd0, mres};
          dv_q  <= '0;
          dv_r  <= '0;
          dcnt  <= 5'd8;
          state <= S_PDIV;
        end
        S_PDIV: begin
          dv_n <= {dv_n[31:0], 4'd0};
          dv_q <= {dv_q[31:0], dig[7:4]};
          dv_r <= dig[3:0];
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd0) begin
            state <= S_PUPD;
          end
        end
        S_PUPD: begin
          kk <= kk - 4'd1;
          if (kk != 4'd1) begin
            pp    <= poly_next;
            state <= S_PMUL;
          end else if (!phase) begin
            e1q   <= poly_next;
            f     <= {1'b0, qq[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}};
            pp    <= ONE_Q32;
            kk    <= 4'(POLY_DEG);
            phase <= 1'b1;
            state <= S_PMUL;
          end else begin
            pp   <= poly_next;
            ecnt <= qq[QUO_W-1:FRAC_BITS];
            if (qq[QUO_W-1:FRAC_BITS] != '0) begin
              state <= S_EMUL;
            end else begin
              state <= S_DEC;
            end
          end
        end
        S_EMUL: begin
          state <= S_EUPD;
        end
        S_EUPD: begin
          // one factor exp(-1) per whole unit of logw
          pp   <= mres;
          ecnt <= ecnt - 4'd1;
          if (ecnt == 4'd1) begin
            state <= S_DEC;
          end else begin
            state <= S_EMUL;
          end
        end
        S_DEC: begin
          acc_f <= ({1'b0, rnd_r} < pp);
          state <= S_WR0;
        end
        S_WR0: begin
          last_r   <= last_next;
          nxt_pair <= last_next ? '0 : (pidx + SLOT_W'(1));
          if (acc_f) begin
            state <= S_WR1;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_WR1: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done && state == S_IDLE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && state == S_IDLE && out_free) begin
      rsp.accepted      <= 1'b0;
      rsp.pair_index    <= '0;
      rsp.sweep_done    <= 1'b0;
      rsp.read_replica  <= '0;
      rsp.read_energy   <= '0;
      rsp.read_attempts <= '0;
      rsp.read_accepts  <= '0;
      if (cmd_r == CMD_READ) begin
        rsp.read_replica  <= rep0_val;
        rsp.read_energy   <= en_rd0;
        rsp.read_attempts <= att_val;
        rsp.read_accepts  <= acc_val;
      end else if (cmd_r == CMD_EXCH && exch_ok) begin
        rsp.accepted   <= acc_f;
        rsp.pair_index <= pidx;
        rsp.sweep_done <= last_r;
      end
    end
  end

endmodule

>>> src/rxs_checker.sv
`timescale 1ns / 1ps
module rxs_checker import rxs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_accepted,
  input logic              rsp_sweep_done,
  input logic [SLOT_W-1:0] rsp_read_replica,
  input logic [CNT_W-1:0]  rsp_read_attempts,
  input logic [EN_W-1:0]   rsp_read_energy
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("ready held across an accepted word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_accepted)
                                   && $stable(rsp_read_energy)))
    else $error("stalled result word changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_accepted || rsp_sweep_done)) |->
      (rsp_read_replica == '0 && rsp_read_attempts == '0 && rsp_read_energy == '0))
    else $error("exchange word carries read fields");

endmodule

bind replica_exchange_swap rxs_checker u_rxs_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_accepted      (rsp.accepted),
  .rsp_sweep_done    (rsp.sweep_done),
  .rsp_read_replica  (rsp.read_replica),
  .rsp_read_attempts (rsp.read_attempts),
  .rsp_read_energy   (rsp.read_energy)
);
